// ===== design/rss_pkg.sv =====
// shared constants, types and helpers for the running sample statistics block
package rss_pkg;
	localparam int SampleBitsDef = 16;
	localparam int CountBitsDef = 24;
	localparam int FracBitsDef = 8;
	localparam int CfgBits = 24;
	localparam int RsdBits = 24;
	localparam logic [CfgBits-1:0] MinMeanReset = 24'd256;
	localparam logic [6:0] PercentScale = 7'd100;

	// input action codes
	localparam logic ActSample = 1'b0;
	localparam logic ActClear = 1'b1;

	// operation codes of the shared divide and root unit
	typedef enum logic [0:0] {
		OP_DIV = 1'b0,
		OP_SQRT = 1'b1
	} op_t;

	// start bundle into the serial unit
	typedef struct packed {
		logic start;
		op_t op;
	} unit_ctl_t;
endpackage

// ===== design/rss_if.sv =====
// valid/ready stream interface carrying one payload
interface rss_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/rss_serial_unit.sv =====
// bit-serial restoring divider and square root sharing one accumulator
module rss_serial_unit
	import rss_pkg::*;
#(
	parameter int W = 128
) (
	input logic clk,
	input logic arst_n,
	input unit_ctl_t ctl,
	input logic [W-1:0] num,
	input logic [W-1:0] den,
	input logic [$clog2(W+1)-1:0] steps,
	output logic busy,
	output logic [W-1:0] result
);
	localparam int CW = $clog2(W+1);

	logic [W-1:0] num_q;
	logic [W-1:0] den_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] res_q;
	logic [CW-1:0] cnt_q;
	op_t op_q;
	logic [W+1:0] rem_sh;
	logic [W+1:0] trial;
	logic take;

	// one quotient or root bit per step
	always_comb begin
		if (op_q == OP_SQRT) begin
			rem_sh = {rem_q, num_q[W-1:W-2]};
			trial = {res_q, 2'b01};
		end else begin
			rem_sh = {1'b0, rem_q, num_q[W-1]};
			trial = {2'b00, den_q};
		end
		take = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q <= ctl.op;
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			res_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= (op_q == OP_SQRT) ? {num_q[W-3:0], 2'b00} : {num_q[W-2:0], 1'b0};
			rem_q <= take ? W'(rem_sh - trial) : W'(rem_sh);
			res_q <= {res_q[W-2:0], take};
		end
	end

	assign busy = (cnt_q != '0);
	assign result = res_q;
endmodule

// ===== design/rss_serial_mul.sv =====
// shift-and-add multiplier, one multiplier bit per cycle
module rss_serial_mul #(
	parameter int W = 128,
	parameter int BW = 32
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [W-1:0] a,
	input logic [BW-1:0] b,
	output logic busy,
	output logic [W-1:0] product
);
	logic [W-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [W-1:0] acc_q;
	logic [$clog2(BW+1)-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= ($clog2(BW+1))'(BW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// add the shifted multiplicand when the low multiplier bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[W-2:0], 1'b0};
			b_q <= {1'b0, b_q[BW-1:1]};
		end
	end

	assign busy = (cnt_q != '0);
	assign product = acc_q;
endmodule

// ===== design/running_sample_statistics.sv =====
// top level: accumulators, sequencer and the shared serial arithmetic
// One beat in gives one beat out. The accumulators update in the cycle an item
// is taken; the derived values then come from a sequencer that drives one
// shift-and-add multiplier and one restoring divide/root unit, each a bit per
// cycle over a 128-bit word. Every operation costs its steps plus a hand-off.
// With the default widths a beat that leaves the count at zero gives its result
// from ST_MEAN without starting a unit; a first sample runs two divisions and a
// root; any later sample runs four divisions of 48, 72, 144 and 136 steps (the
// last only for the relative deviation), two roots of 64 steps and three
// multiplies of 40 steps. The result is held until accepted, and the input is
// ready again in the cycle after the result beat has left the output register.
module running_sample_statistics
	import rss_pkg::*;
#(
	parameter int SAMPLE_BITS = SampleBitsDef,
	parameter int COUNT_BITS = CountBitsDef,
	parameter int FRAC_BITS = FracBitsDef
) (
	input logic clk,
	input logic arst_n,
	rss_stream_if.sink in_ch,
	rss_stream_if.source out_ch,
	rss_stream_if.sink cfg
);
	localparam int VB = SAMPLE_BITS + FRAC_BITS;
	localparam int W = 128;
	localparam int CW = $clog2(W+1);
	localparam int SUMB = SAMPLE_BITS + COUNT_BITS;
	localparam int SQB = 2 * SAMPLE_BITS + COUNT_BITS;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MEAN  = 10'b0000000010,
		ST_RMSD  = 10'b0000000100,
		ST_RMSQ  = 10'b0000001000,
		ST_MULA  = 10'b0000010000,
		ST_MULB  = 10'b0000100000,
		ST_MULD  = 10'b0001000000,
		ST_SGD   = 10'b0010000000,
		ST_SGQ   = 10'b0100000000,
		ST_RSD   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic wait_q;
	logic launch_q;
	logic out_valid_q;
	logic [CfgBits-1:0] min_mean_q;
	logic [COUNT_BITS-1:0] count_q;
	logic signed [SAMPLE_BITS-1:0] last_q, min_q, max_q;
	logic signed [SUMB-1:0] sum_q;
	logic [SQB-1:0] sq_q;
	logic [VB-1:0] amean_q, sigma_q, rms_q;
	logic [RsdBits-1:0] rsd_q;
	logic [W-1:0] prod_a_q;
	logic [W-1:0] dd_q;
	logic [W-1:0] quo_q;

	logic signed [SAMPLE_BITS-1:0] s_in;
	logic [COUNT_BITS-1:0] cmax;
	logic [SUMB-1:0] asum;
	logic [SAMPLE_BITS-1:0] smag;

	unit_ctl_t uctl;
	logic [W-1:0] unum, uden, ures;
	logic [CW-1:0] usteps;
	logic ubusy;
	logic mstart;
	logic [W-1:0] ma, mprod;
	logic [SUMB-1:0] mb;
	logic mbusy;
	logic in_fire;

	assign cmax = '1;
	assign s_in = in_ch.data.sample_value;
	assign asum = sum_q[SUMB-1] ? SUMB'(-sum_q) : SUMB'(sum_q);
	assign smag = s_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s_in) : SAMPLE_BITS'(s_in);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign cfg.ready = 1'b1;

	rss_serial_unit #(.W(W)) u_unit (
		.clk, .arst_n, .ctl(uctl), .num(unum), .den(uden), .steps(usteps),
		.busy(ubusy), .result(ures)
	);

	rss_serial_mul #(.W(W), .BW(SUMB)) u_mul (
		.clk, .arst_n, .start(mstart), .a(ma), .b(mb), .busy(mbusy), .product(mprod)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mean_q <= MinMeanReset;
		end else if (cfg.valid && cfg.ready) begin
			min_mean_q <= cfg.data;
		end
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; last_q <= '0; min_q <= '0; max_q <= '0;
			sum_q <= '0; sq_q <= '0;
		end else if (in_fire) begin
			if (in_ch.data.action == ActClear) begin
				count_q <= '0; last_q <= '0; min_q <= '0; max_q <= '0;
				sum_q <= '0; sq_q <= '0;
			end else begin
				last_q <= s_in;
				if (count_q != cmax) begin
					count_q <= count_q + 1'b1;
					if (count_q == '0 || s_in < min_q) min_q <= s_in;
					if (count_q == '0 || s_in > max_q) max_q <= s_in;
					sum_q <= sum_q + SUMB'(s_in);
					sq_q <= sq_q + SQB'(smag) * SQB'(smag);
				end
			end
		end
	end

	// unit start requests per state
	always_comb begin
		uctl = '{start: 1'b0, op: OP_DIV};
		unum = '0; uden = '0; usteps = '0;
		mstart = 1'b0; ma = '0; mb = '0;
		if (launch_q) begin
			unique case (state_q)
				ST_MEAN: begin
					if (count_q != '0) begin
						uctl = '{start: 1'b1, op: OP_DIV};
						unum = W'(asum) << (W - SUMB);
						uden = W'(count_q);
						usteps = CW'(SUMB + FRAC_BITS);
					end
				end
				ST_RMSD: begin
					uctl = '{start: 1'b1, op: OP_DIV};
					unum = W'(sq_q) << (W - SQB);
					uden = W'(count_q);
					usteps = CW'(SQB + 2 * FRAC_BITS);
				end
				ST_RMSQ: begin
					uctl = '{start: 1'b1, op: OP_SQRT};
					unum = quo_q;
					usteps = CW'(W / 2);
				end
				ST_MULA: begin
					mstart = 1'b1; ma = W'(sq_q); mb = SUMB'(count_q);
				end
				ST_MULB: begin
					mstart = 1'b1; ma = W'(asum); mb = asum;
				end
				ST_MULD: begin
					mstart = 1'b1; ma = W'(count_q);
					mb = SUMB'(count_q - 1'b1);
				end
				ST_SGD: begin
					uctl = '{start: 1'b1, op: OP_DIV};
					unum = dd_q;
					uden = mprod;
					usteps = CW'(W + 2 * FRAC_BITS);
				end
				ST_SGQ: begin
					uctl = '{start: 1'b1, op: OP_SQRT};
					unum = quo_q;
					usteps = CW'(W / 2);
				end
				ST_RSD: begin
					uctl = '{start: 1'b1, op: OP_DIV};
					unum = W'(sigma_q) * W'(PercentScale);
					uden = W'(amean_q);
					usteps = CW'(W + FRAC_BITS);
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; launch_q <= 1'b0; wait_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (launch_q) wait_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_MEAN; launch_q <= 1'b1; wait_q <= 1'b0;
					end
				end
				default: begin
					if (state_q == ST_MEAN && launch_q && count_q == '0) begin
						state_q <= ST_IDLE; out_valid_q <= 1'b1;
					end else if (wait_q && !launch_q && !ubusy && !mbusy) begin
						wait_q <= 1'b0;
						unique case (state_q)
							ST_MEAN: begin state_q <= ST_RMSD; launch_q <= 1'b1; end
							ST_RMSD: begin state_q <= ST_RMSQ; launch_q <= 1'b1; end
							ST_RMSQ: begin
								if (count_q < 2) begin
									state_q <= ST_IDLE; out_valid_q <= 1'b1;
								end else begin
									state_q <= ST_MULA; launch_q <= 1'b1;
								end
							end
							ST_MULA: begin state_q <= ST_MULB; launch_q <= 1'b1; end
							ST_MULB: begin state_q <= ST_MULD; launch_q <= 1'b1; end
							ST_MULD: begin state_q <= ST_SGD; launch_q <= 1'b1; end
							ST_SGD: begin state_q <= ST_SGQ; launch_q <= 1'b1; end
							ST_SGQ: begin
								if (amean_q != '0 && CfgBits'(amean_q) >= min_mean_q
									&& VB <= CfgBits) begin
									state_q <= ST_RSD; launch_q <= 1'b1;
								end else if (amean_q != '0 && VB > CfgBits
									&& amean_q >= VB'(min_mean_q)) begin
									state_q <= ST_RSD; launch_q <= 1'b1;
								end else begin
									state_q <= ST_IDLE; out_valid_q <= 1'b1;
								end
							end
							ST_RSD: begin state_q <= ST_IDLE; out_valid_q <= 1'b1; end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
			endcase
		end
	end

	// capture unit results
	always_ff @(posedge clk) begin
		if (in_fire) begin
			amean_q <= '0; sigma_q <= '0; rsd_q <= '0; rms_q <= '0;
		end else if (wait_q && !launch_q && !ubusy && !mbusy) begin
			case (state_q)
				ST_MEAN: amean_q <= VB'(ures);
				ST_RMSD: quo_q <= ures;
				ST_RMSQ: rms_q <= (ures > W'({VB{1'b1}})) ? '1 : VB'(ures);
				ST_MULA: prod_a_q <= mprod;
				ST_MULB: dd_q <= (prod_a_q >= mprod) ? prod_a_q - mprod : mprod - prod_a_q;
				ST_SGD: quo_q <= ures;
				ST_SGQ: sigma_q <= (ures > W'({VB{1'b1}})) ? '1 : VB'(ures);
				ST_RSD: rsd_q <= (ures > W'({RsdBits{1'b1}})) ? '1 : RsdBits'(ures);
				default: begin
				end
			endcase
		end
	end

	// result beat
	assign out_ch.valid = out_valid_q;
	assign out_ch.data.sample_count = count_q;
	assign out_ch.data.last_sample = last_q;
	assign out_ch.data.minimum = min_q;
	assign out_ch.data.maximum = max_q;
	assign out_ch.data.mean = sum_q[SUMB-1] ? VB'(-amean_q) : VB'(amean_q);
	assign out_ch.data.sigma = sigma_q;
	assign out_ch.data.rsd_percent = rsd_q;
	assign out_ch.data.rms = rms_q;
	assign out_ch.data.count_full = (count_q == cmax);

`ifndef ASSERT_OFF
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready) else $error("input taken while busy");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(ubusy && mbusy)) else $error("both serial units busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (state_q == ST_IDLE)) else $error("result while busy");
`endif
endmodule

// ===== test/tb_running_sample_statistics.sv =====
// testbench for running_sample_statistics: queued stimulus, bit-true statistics predictor
module tb_running_sample_statistics;
	import rss_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W = SampleBitsDef;
	localparam int COUNT_W = CountBitsDef;
	localparam int FRAC_W = FracBitsDef;
	localparam int VAL_W = SAMPLE_W + FRAC_W;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 400;
	localparam int DRAIN_CYCLES = 40;

	localparam logic ACT_SAMPLE = ActSample;
	localparam logic ACT_CLEAR = ActClear;

	typedef struct packed {
		logic action;
		logic signed [SAMPLE_W-1:0] sample_value;
	} stat_in_t;

	typedef struct packed {
		logic [COUNT_W-1:0] sample_count;
		logic signed [SAMPLE_W-1:0] last_sample;
		logic signed [SAMPLE_W-1:0] minimum;
		logic signed [SAMPLE_W-1:0] maximum;
		logic signed [VAL_W-1:0] mean;
		logic [VAL_W-1:0] sigma;
		logic [RsdBits-1:0] rsd_percent;
		logic [VAL_W-1:0] rms;
		logic count_full;
	} stat_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rss_stream_if #(.payload_t(stat_in_t)) in_if ();
	rss_stream_if #(.payload_t(stat_out_t)) out_if ();
	rss_stream_if #(.payload_t(logic [CfgBits-1:0])) cfg_if ();

	running_sample_statistics u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_if.sink),
		.out_ch(out_if.source),
		.cfg(cfg_if.sink)
	);

	always #2 clk = ~clk;

	// pending stimulus, expected results and the predictor state
	stat_in_t pending_items[$];
	stat_out_t expected_stats[$];
	logic [COUNT_W-1:0] acc_count;
	logic signed [SAMPLE_W-1:0] acc_last, acc_min, acc_max;
	logic signed [39:0] acc_sum;
	logic [55:0] acc_sqsum;
	logic [CfgBits-1:0] rsd_floor;
	int error_count = 0;
	int items_taken = 0;
	int results_seen = 0;
	int cycle_count = 0;
	bit no_idle = 0;

	// integer square root, floor
	function automatic logic [63:0] isqrt(logic [127:0] a);
		logic [127:0] rem, res, trial;
		rem = '0;
		res = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 2) | ((a >> (2 * i)) & 128'd3);
			trial = (res << 2) | 128'd1;
			res = res << 1;
			if (rem >= trial) begin
				rem = rem - trial;
				res = res | 128'd1;
			end
		end
		return res[63:0];
	endfunction

	function automatic logic [VAL_W-1:0] sat_val(logic [127:0] v);
		return (v > {VAL_W{1'b1}}) ? {VAL_W{1'b1}} : v[VAL_W-1:0];
	endfunction

	// apply one item to the accumulators and derive the reported statistics
	function automatic stat_out_t stats_update(stat_in_t it);
		stat_out_t r;
		logic signed [127:0] ssum;
		logic [127:0] n, asum, amean, a, b, dd, sig, rsd;
		r = '0;
		if (it.action == ACT_CLEAR) begin
			acc_count = '0;
			acc_last = '0;
			acc_min = '0;
			acc_max = '0;
			acc_sum = '0;
			acc_sqsum = '0;
		end else begin
			acc_last = it.sample_value;
			if (acc_count != {COUNT_W{1'b1}}) begin
				acc_count = acc_count + 1'b1;
				if (acc_count == 1) begin
					acc_min = it.sample_value;
					acc_max = it.sample_value;
				end else begin
					if (it.sample_value < acc_min) acc_min = it.sample_value;
					if (it.sample_value > acc_max) acc_max = it.sample_value;
				end
				acc_sum = acc_sum + it.sample_value;
				acc_sqsum = acc_sqsum + 56'(it.sample_value) * 56'(it.sample_value);
			end
		end
		n = 128'(acc_count);
		ssum = acc_sum;
		asum = (ssum < 0) ? 128'(-ssum) : 128'(ssum);
		amean = '0;
		sig = '0;
		rsd = '0;
		if (n > 0) begin
			amean = (asum << FRAC_W) / n;
			r.mean = (ssum < 0) ? VAL_W'(-amean) : VAL_W'(amean);
			r.rms = sat_val(128'(isqrt((128'(acc_sqsum) << (2 * FRAC_W)) / n)));
			r.minimum = acc_min;
			r.maximum = acc_max;
		end
		if (n >= 2) begin
			a = 128'(acc_sqsum) * n;
			b = asum * asum;
			dd = (a >= b) ? a - b : b - a;
			sig = 128'(sat_val(128'(isqrt((dd << (2 * FRAC_W)) / (n * (n - 1))))));
			if (amean != 0 && amean >= 128'(rsd_floor)) begin
				rsd = ((sig * 128'(PercentScale)) << FRAC_W) / amean;
				r.rsd_percent = (rsd > {RsdBits{1'b1}}) ? {RsdBits{1'b1}} : rsd[RsdBits-1:0];
			end
		end
		r.sigma = sig[VAL_W-1:0];
		r.sample_count = acc_count;
		r.last_sample = acc_last;
		r.count_full = (acc_count == {COUNT_W{1'b1}});
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int p;
		if (no_idle) return 0;
		p = $urandom_range(99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// input driver: takes items from the pending queue, predicts on each accepted beat
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_if.valid && in_if.ready) begin
				expected_stats.push_back(stats_update(in_if.data));
				items_taken++;
			end
			if (!in_if.valid || in_if.ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_if.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_if.data <= pending_items.pop_front();
					in_if.valid <= 1'b1;
					in_gap <= idle_len();
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	int out_gap = 0;
	always @(posedge clk) begin
		stat_out_t got, want;
		if (arst_n) begin
			if (out_if.valid && out_if.ready) begin
				got = out_if.data;
				results_seen++;
				if (expected_stats.size() == 0) begin
					$error("result beat with nothing expected");
					error_count++;
				end else begin
					want = expected_stats.pop_front();
					if (got.sample_count !== want.sample_count) begin
						$error("sample_count exp %0d got %0d", want.sample_count, got.sample_count);
						error_count++;
					end
					if (got.last_sample !== want.last_sample) begin
						$error("last_sample exp %0d got %0d", want.last_sample, got.last_sample);
						error_count++;
					end
					if (got.minimum !== want.minimum) begin
						$error("minimum exp %0d got %0d", want.minimum, got.minimum);
						error_count++;
					end
					if (got.maximum !== want.maximum) begin
						$error("maximum exp %0d got %0d", want.maximum, got.maximum);
						error_count++;
					end
					if (got.mean !== want.mean) begin
						$error("mean exp %0d got %0d", want.mean, got.mean);
						error_count++;
					end
					if (got.sigma !== want.sigma) begin
						$error("sigma exp %0d got %0d", want.sigma, got.sigma);
						error_count++;
					end
					if (got.rsd_percent !== want.rsd_percent) begin
						$error("rsd_percent exp %0d got %0d", want.rsd_percent, got.rsd_percent);
						error_count++;
					end
					if (got.rms !== want.rms) begin
						$error("rms exp %0d got %0d", want.rms, got.rms);
						error_count++;
					end
					if (got.count_full !== want.count_full) begin
						$error("count_full exp %0d got %0d", want.count_full, got.count_full);
						error_count++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_if.ready <= 1'b0;
			end else begin
				out_gap <= idle_len();
				out_if.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic push_item(logic act, logic signed [SAMPLE_W-1:0] v);
		stat_in_t it;
		it.action = act;
		it.sample_value = v;
		pending_items.push_back(it);
	endtask

	// wait until every queued beat has gone out and the block has settled
	task automatic drain();
		while (pending_items.size() > 0 || in_if.valid || expected_stats.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_floor(logic [CfgBits-1:0] v);
		cfg_if.data <= v;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		rsd_floor = v;
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// random sample: full range, small values around zero, or a tight cluster
	function automatic logic signed [SAMPLE_W-1:0] rand_sample(int style, int centre);
		case (style)
			0: return SAMPLE_W'($urandom);
			1: return SAMPLE_W'($signed($urandom_range(0, 20)) - 10);
			default: return SAMPLE_W'(centre + $signed($urandom_range(0, 6)) - 3);
		endcase
	endfunction

	initial begin
		logic [CfgBits-1:0] floors[5];
		int style, centre, per_phase;
		in_if.valid = 1'b0;
		in_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		out_if.ready = 1'b0;
		acc_count = '0;
		acc_last = '0;
		acc_min = '0;
		acc_max = '0;
		acc_sum = '0;
		acc_sqsum = '0;
		rsd_floor = MinMeanReset;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty stats, one sample, extremes, zero mean, mean near the floor
		push_item(ACT_CLEAR, 16'sd1234);
		push_item(ACT_SAMPLE, 16'sd32767);
		push_item(ACT_SAMPLE, 16'sd32767);
		push_item(ACT_SAMPLE, -16'sd32768);
		push_item(ACT_SAMPLE, -16'sd32768);
		push_item(ACT_SAMPLE, 16'sd0);
		push_item(ACT_CLEAR, -16'sd1);
		push_item(ACT_SAMPLE, 16'sd5);
		push_item(ACT_SAMPLE, -16'sd5);
		push_item(ACT_CLEAR, 16'sd0);
		push_item(ACT_SAMPLE, 16'sd1);
		push_item(ACT_SAMPLE, 16'sd1);
		push_item(ACT_SAMPLE, 16'sd0);
		push_item(ACT_SAMPLE, 16'sd2);
		push_item(ACT_CLEAR, 16'sd0);
		push_item(ACT_SAMPLE, -16'sd32768);
		push_item(ACT_SAMPLE, -16'sd32767);
		push_item(ACT_SAMPLE, 16'sd1);
		push_item(ACT_SAMPLE, -16'sd1);
		drain();

		// random phases, each under its own rsd floor
		floors[0] = 24'd0;
		floors[1] = 24'd8388608;
		floors[2] = 24'd1;
		floors[3] = CfgBits'($urandom_range(0, 24'hFFFFFF));
		floors[4] = MinMeanReset;
		per_phase = RANDOM_ITEMS / 5;
		for (int ph = 0; ph < 5; ph++) begin
			write_floor(floors[ph]);
			no_idle = (ph == 2);
			style = $urandom_range(0, 2);
			centre = $signed($urandom_range(0, 65535)) - 32768;
			for (int k = 0; k < per_phase; k++) begin
				if ($urandom_range(99) < 4) begin
					push_item(ACT_CLEAR, SAMPLE_W'($urandom));
					style = $urandom_range(0, 2);
					centre = $signed($urandom_range(0, 65535)) - 32768;
				end else begin
					push_item(ACT_SAMPLE, rand_sample(style, centre));
				end
			end
			drain();
		end
		no_idle = 0;

		$display("%0d items in, %0d results checked, rsd floor swept from 0 to 8388608",
			items_taken, results_seen);
		$display("covered empty, single-sample, zero-mean, extreme and clustered statistics");
		if (error_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
